// ===== rtl/radix_integer_to_text_unit_defines.svh =====
`ifndef RADIX_INTEGER_TO_TEXT_UNIT_DEFINES_SVH
`define RADIX_INTEGER_TO_TEXT_UNIT_DEFINES_SVH

// assertion checked outside reset
`define RIT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// assertion checked at every edge, reset included
`define RIT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/rit_pkg.sv =====
package rit_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int NUM_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 5;
    localparam int DIG_W       = $clog2(MAX_RADIX);
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int STEP_W      = $clog2(NUM_W);
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int TAB_W       = 2 * CFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0] BASE_LENGTH_RST = 5'd10;
    localparam logic [CFG_W-1:0]  DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]  DIGITS_HIGH_RST = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_LOWEST  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HIGHEST = 8'h7E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SIGN,
        ST_READ,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic [DIG_W-1:0] remainder;
    } t_div_res;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [TAB_W-1:0] tab,
                                                     input logic [DIG_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = tab[{idx, 3'b000} +: CHAR_W];
        return c;
    endfunction

    function automatic logic char_bad(input logic [CHAR_W-1:0] c);
        logic b;
        b = (c == CH_MINUS) || (c == CH_PLUS) || (c < CH_LOWEST) || (c > CH_HIGHEST);
        return b;
    endfunction

endpackage

// ===== rtl/rit_divider.sv =====
module rit_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rit_pkg::NUM_W-1:0]     i_dividend,
    input  logic [rit_pkg::BASE_W-1:0]    i_divisor,
    output rit_pkg::t_div_res             o_res
);

    logic                          r_busy;
    logic                          r_done;
    logic [rit_pkg::STEP_W-1:0]    r_step;
    logic [rit_pkg::NUM_W-1:0]     r_quo;
    logic [rit_pkg::DIG_W-1:0]     r_rem;
    logic [rit_pkg::BASE_W-1:0]    w_trial;
    logic                          w_fit;
    logic [rit_pkg::BASE_W-1:0]    w_diff;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[rit_pkg::NUM_W-1]};
    assign w_fit   = (w_trial >= i_divisor);
    assign w_diff  = w_trial - i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == {rit_pkg::STEP_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[rit_pkg::NUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[rit_pkg::DIG_W-1:0] : w_trial[rit_pkg::DIG_W-1:0];
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

// ===== rtl/radix_integer_to_text_unit.sv =====
// channel  | handshake           | payload
// input    | i_valid / o_ready   | i_number
// output   | o_valid / i_ready   | o_character, o_last
// config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// one number at a time: a check of the digit table, then one divide per digit
// in the shared bit-serial divider, then the sign, if any, and a read and a put per digit.
// each divide is one run of the 32-step divider loop.
// the last character of a result waits in the output register while the next number is taken.
// reset is synchronous, active low; a stalled output holds the character.
module radix_integer_to_text_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [rit_pkg::NUM_W-1:0] i_number,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rit_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [rit_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rit_pkg::CFG_W-1:0]        i_cfg_data
);

    rit_pkg::t_state               r_state;
    rit_pkg::t_state               n_state;
    logic [rit_pkg::BASE_W-1:0]    r_base_len;
    logic [rit_pkg::CFG_W-1:0]     r_digits_low;
    logic [rit_pkg::CFG_W-1:0]     r_digits_high;
    logic [rit_pkg::TAB_W-1:0]     w_tab;
    logic                          r_neg;
    logic [rit_pkg::NUM_W-1:0]     r_mag;
    logic [rit_pkg::DIG_W-1:0]     r_chk;
    logic [rit_pkg::CNT_W-1:0]     r_cnt;
    logic [rit_pkg::CNT_W-1:0]     w_rd_idx;
    logic [rit_pkg::DIG_W-1:0]     r_digit_mem [rit_pkg::MAX_DIGITS];
    logic [rit_pkg::DIG_W-1:0]     r_rd_data;
    logic                          r_o_valid;
    logic [rit_pkg::CHAR_W-1:0]    r_o_char;
    logic                          r_o_last;
    rit_pkg::t_div_res             w_div;

    logic                          w_in_xfer;
    logic                          w_len_ok;
    logic                          w_chk_bad;
    logic                          w_chk_end;
    logic                          w_out_free;
    logic                          w_div_start;
    logic                          w_wr_en;
    logic                          w_rd_en;
    logic                          w_load_sign;
    logic                          w_load_digit;
    logic                          w_more;

    assign w_tab     = {r_digits_high, r_digits_low};
    assign w_in_xfer = i_valid && o_ready;
    assign w_len_ok  = (r_base_len >= 5'd2) && (r_base_len <= 5'(rit_pkg::MAX_RADIX));
    assign w_chk_end = ({1'b0, r_chk} + 5'd1) == r_base_len;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_rd_idx  = r_cnt - 1'b1;
    assign w_more    = (w_div.quotient != '0) && (r_cnt != (rit_pkg::CNT_W)'(rit_pkg::MAX_DIGITS - 1));

    // digit under check against bad codes and every earlier digit
    always_comb begin
        logic [rit_pkg::CHAR_W-1:0] c;
        c = rit_pkg::digit_char(w_tab, r_chk);
        w_chk_bad = rit_pkg::char_bad(c);
        for (int k = 0; k < rit_pkg::MAX_RADIX; k++) begin
            if ((k < int'(r_chk)) && (rit_pkg::digit_char(w_tab, rit_pkg::DIG_W'(k)) == c)) begin
                w_chk_bad = 1'b1;
            end
        end
    end

    rit_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_base_len),
        .o_res      (w_div)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rit_pkg::ST_IDLE: begin
                if (w_in_xfer && w_len_ok) begin
                    n_state = rit_pkg::ST_CHECK;
                end
            end
            rit_pkg::ST_CHECK: begin
                if (w_chk_bad) begin
                    n_state = rit_pkg::ST_IDLE;
                end else if (w_chk_end) begin
                    n_state = rit_pkg::ST_DIV_START;
                end
            end
            rit_pkg::ST_DIV_START: begin
                n_state = rit_pkg::ST_DIV_WAIT;
            end
            rit_pkg::ST_DIV_WAIT: begin
                if (w_div.done) begin
                    n_state = w_more ? rit_pkg::ST_DIV_START : rit_pkg::ST_SIGN;
                end
            end
            rit_pkg::ST_SIGN: begin
                if (!r_neg || w_out_free) begin
                    n_state = rit_pkg::ST_READ;
                end
            end
            rit_pkg::ST_READ: begin
                n_state = rit_pkg::ST_PUT;
            end
            rit_pkg::ST_PUT: begin
                if (w_out_free) begin
                    n_state = (r_cnt == (rit_pkg::CNT_W)'(1)) ? rit_pkg::ST_IDLE : rit_pkg::ST_READ;
                end
            end
            default: begin
                n_state = rit_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        w_div_start  = 1'b0;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_load_sign  = 1'b0;
        w_load_digit = 1'b0;
        unique case (r_state)
            rit_pkg::ST_IDLE:      o_ready = 1'b1;
            rit_pkg::ST_CHECK:     ;
            rit_pkg::ST_DIV_START: w_div_start = 1'b1;
            rit_pkg::ST_DIV_WAIT:  w_wr_en = w_div.done;
            rit_pkg::ST_SIGN:      w_load_sign = r_neg && w_out_free;
            rit_pkg::ST_READ:      w_rd_en = 1'b1;
            rit_pkg::ST_PUT:       w_load_digit = w_out_free;
            default:               ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rit_pkg::ST_IDLE;
            r_base_len    <= rit_pkg::BASE_LENGTH_RST;
            r_digits_low  <= rit_pkg::DIGITS_LOW_RST;
            r_digits_high <= rit_pkg::DIGITS_HIGH_RST;
            r_o_valid     <= 1'b0;
            r_chk         <= '0;
            r_cnt         <= '0;
            r_mag         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rit_pkg::CFG_BASE_LENGTH: r_base_len    <= i_cfg_data[rit_pkg::BASE_W-1:0];
                    rit_pkg::CFG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                    rit_pkg::CFG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                    default:                  ;
                endcase
            end
            if (w_in_xfer) begin
                r_mag <= i_number[rit_pkg::NUM_W-1] ? (32'd0 - i_number) : i_number;
                r_chk <= '0;
                r_cnt <= '0;
            end else if (r_state == rit_pkg::ST_CHECK) begin
                r_chk <= r_chk + 1'b1;
            end else if (w_wr_en) begin
                r_mag <= w_div.quotient;
                r_cnt <= r_cnt + 1'b1;
            end else if (w_load_digit) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_load_sign || w_load_digit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_neg <= i_number[rit_pkg::NUM_W-1];
        end
        if (w_load_sign) begin
            r_o_char <= rit_pkg::CH_MINUS;
            r_o_last <= 1'b0;
        end else if (w_load_digit) begin
            r_o_char <= rit_pkg::digit_char(w_tab, r_rd_data);
            r_o_last <= (r_cnt == (rit_pkg::CNT_W)'(1));
        end
    end

    // digit buffer, least significant digit at entry zero
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_digit_mem[r_cnt[rit_pkg::ADDR_W-1:0]] <= w_div.remainder;
        end
        if (w_rd_en) begin
            r_rd_data <= r_digit_mem[w_rd_idx[rit_pkg::ADDR_W-1:0]];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

endmodule

// ===== rtl/rit_checker.sv =====
`include "radix_integer_to_text_unit_defines.svh"

module rit_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [rit_pkg::CHAR_W-1:0]       o_character,
    input  logic                             o_last
);

    // stalled transfer holds its character
    `RIT_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
    // a sign is never the last character
    `RIT_ASSERT(a_sign_not_last, i_clk, i_rst_n, o_valid && (o_character == rit_pkg::CH_MINUS) |-> !o_last)
    // only printable characters leave a checked base
    `RIT_ASSERT(a_printable, i_clk, i_rst_n, o_valid |-> (o_character >= rit_pkg::CH_LOWEST) && (o_character <= rit_pkg::CH_HIGHEST))
    // nothing on the output after reset
    `RIT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind radix_integer_to_text_unit rit_checker u_rit_checker (.*);
